/* hw/rtl/eltt_pkg.sv */
// Package for the event last-time table: sizes, command and status codes, sequencer states.
// Used by the top level and the checker; no dependencies.
`default_nettype none
package eltt_pkg;
   localparam int PendingDepthDefault = 64;
   localparam int TableDepthDefault   = 1024;
   localparam int IdW   = 32;
   localparam int TimeW = 32;
   localparam int CmdW  = 3;
   localparam int IdxW  = 10;
   localparam int SizeW = 11;
   localparam int StatW = 3;

   typedef enum logic [CmdW-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_LOOKUP  = 3'd2,
      CMD_READ    = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [StatW-1:0] {
      ST_OK        = 3'd0,
      ST_BACKWARD  = 3'd1,
      ST_PEND_FULL = 3'd2,
      ST_TAB_FULL  = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INS_RD, S_INS_CMP,
      S_ADV_PRD, S_ADV_PGET,
      S_BS_RD, S_BS_CMP,
      S_SH_RD, S_SH_WR,
      S_LK_RD, S_LK_CMP,
      S_RD_RD, S_RD_GET,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

/* hw/rtl/eltt_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module eltt_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output      logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/event_last_time_table_unit.sv */
// Top level of the event last-time table: pending set, sorted id/time table, sequencer.
// Depends on eltt_pkg and eltt_ram.
//
//  channel | ports                                           | dir
//  req     | req_valid req_ready req_command req_event_id    | in
//          | req_time_value req_entry_index                  |
//  rsp     | rsp_valid rsp_ready rsp_found rsp_id_out ...    | out
//
// Insert: scans the pending entries (up to PENDING_DEPTH), appends the id if new.
// Advance: per pending id a fetch from the pending RAM, a binary search of
// the table and, on a new id, an entry-by-entry shift of the table tail, the
// table work all on its one RAM port.
// Lookup: binary search of the table; read by index: one table read; clear: no table access.
// Reset clears counts and time; req_ready is low while an item is in work or
// its result waits for rsp_ready.
`default_nettype none
module event_last_time_table_unit
   import eltt_pkg::*;
#(
   parameter int PENDING_DEPTH = PendingDepthDefault,
   parameter int TABLE_DEPTH   = TableDepthDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [CmdW-1:0]  req_command,
   input  wire logic [IdW-1:0]   req_event_id,
   input  wire logic [TimeW-1:0] req_time_value,
   input  wire logic [IdxW-1:0]  req_entry_index,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      logic             rsp_found,
   output      logic [IdW-1:0]   rsp_id_out,
   output      logic [TimeW-1:0] rsp_time_out,
   output      logic             rsp_time_is_start,
   output      logic [SizeW-1:0] rsp_table_size,
   output      logic [StatW-1:0] rsp_status
);
   localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int PCW = $clog2(PENDING_DEPTH + 1);
   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int TCW = $clog2(TABLE_DEPTH + 1);
   localparam int EW  = IdW + TimeW + 1;
   localparam int CW  = (TCW > IdxW) ? TCW : IdxW;

   state_type state_ff, state_in;
   logic [CmdW-1:0]  cmd_ff, cmd_in;
   logic [IdW-1:0]   key_ff, key_in;
   logic [TimeW-1:0] tnew_ff, tnew_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [PCW-1:0]   pcnt_ff, pcnt_in, pi_ff, pi_in;
   logic [TCW-1:0]   tcnt_ff, tcnt_in, lo_ff, lo_in, hi_ff, hi_in, sp_ff, sp_in;
   logic [TimeW-1:0] ctime_ff, ctime_in;
   logic             cstart_ff, cstart_in;
   logic [TimeW-1:0] otime_ff, otime_in;
   logic             ostart_ff, ostart_in;
   logic [EW-1:0]    hold_ff, hold_in;
   logic             found_ff, found_in;
   logic [IdW-1:0]   rid_ff, rid_in;
   logic [TimeW-1:0] rtime_ff, rtime_in;
   logic             rstart_ff, rstart_in;
   logic [StatW-1:0] stat_ff, stat_in;
   logic             seen_ff, seen_in;

   logic            p_we;
   logic [PAW-1:0]  p_addr;
   logic [IdW-1:0]  p_wdata, p_rdata;
   logic            t_we;
   logic [TAW-1:0]  t_addr;
   logic [EW-1:0]   t_wdata, t_rdata;
   logic [TCW-1:0]  mid;
   logic [IdW-1:0]  t_id;

   eltt_ram #(.Width(IdW), .Depth(PENDING_DEPTH)) u_pend (
      .clock(clock), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
   eltt_ram #(.Width(EW), .Depth(TABLE_DEPTH)) u_tab (
      .clock(clock), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata));

   assign t_id = t_rdata[EW-1 -: IdW];
   assign mid  = TCW'((({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pcnt_ff   <= '0;
         tcnt_ff   <= '0;
         ctime_ff  <= '0;
         cstart_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         pcnt_ff   <= pcnt_in;
         tcnt_ff   <= tcnt_in;
         ctime_ff  <= ctime_in;
         cstart_ff <= cstart_in;
      end
      cmd_ff <= cmd_in; key_ff <= key_in; tnew_ff <= tnew_in; idx_ff <= idx_in;
      pi_ff <= pi_in; lo_ff <= lo_in; hi_ff <= hi_in; sp_ff <= sp_in;
      otime_ff <= otime_in; ostart_ff <= ostart_in; hold_ff <= hold_in;
      found_ff <= found_in; rid_ff <= rid_in; rtime_ff <= rtime_in;
      rstart_ff <= rstart_in; stat_ff <= stat_in; seen_ff <= seen_in;
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; key_in = key_ff; tnew_in = tnew_ff;
      idx_in = idx_ff; pcnt_in = pcnt_ff; pi_in = pi_ff; tcnt_in = tcnt_ff;
      lo_in = lo_ff; hi_in = hi_ff; sp_in = sp_ff; ctime_in = ctime_ff;
      cstart_in = cstart_ff; otime_in = otime_ff; ostart_in = ostart_ff;
      hold_in = hold_ff; found_in = found_ff; rid_in = rid_ff; rtime_in = rtime_ff;
      rstart_in = rstart_ff; stat_in = stat_ff; seen_in = seen_ff;
      p_we = 1'b0; p_addr = pi_ff[PAW-1:0]; p_wdata = key_ff;
      t_we = 1'b0; t_addr = mid[TAW-1:0]; t_wdata = hold_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_command; key_in = req_event_id;
               tnew_in = req_time_value; idx_in = req_entry_index;
               found_in = 1'b0; rid_in = '0; rtime_in = '0; rstart_in = 1'b0;
               stat_in = ST_OK; seen_in = 1'b0; pi_in = '0;
               lo_in = '0; hi_in = tcnt_ff;
               state_in = S_RESP;
               case (cmd_type'(req_command))
                  CMD_INSERT:  state_in = S_INS_RD;
                  CMD_ADVANCE: begin
                     if (!cstart_ff && req_time_value < ctime_ff) stat_in = ST_BACKWARD;
                     else if (cstart_ff || req_time_value != ctime_ff) begin
                        otime_in = ctime_ff; ostart_in = cstart_ff;
                        state_in = S_ADV_PRD;
                     end
                  end
                  CMD_LOOKUP:  state_in = S_LK_RD;
                  CMD_READ: begin
                     if (CW'(req_entry_index) < CW'(tcnt_ff)) state_in = S_RD_RD;
                     else stat_in = ST_BAD_INDEX;
                  end
                  CMD_CLEAR: begin
                     pcnt_in = '0; tcnt_in = '0; ctime_in = '0; cstart_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_INS_RD: begin
            if (pi_ff < pcnt_ff) state_in = S_INS_CMP;
            else if (seen_ff) state_in = S_RESP;
            else if (pcnt_ff >= PCW'(PENDING_DEPTH)) begin
               stat_in = ST_PEND_FULL; state_in = S_RESP;
            end else begin
               p_we = 1'b1; p_addr = pcnt_ff[PAW-1:0];
               pcnt_in = pcnt_ff + 1'b1; state_in = S_RESP;
            end
         end
         S_INS_CMP: begin
            if (p_rdata == key_ff) seen_in = 1'b1;
            pi_in = pi_ff + 1'b1; state_in = S_INS_RD;
         end
         S_ADV_PRD: begin
            if (pi_ff < pcnt_ff) state_in = S_ADV_PGET;
            else begin
               pcnt_in = '0; ctime_in = tnew_ff; cstart_in = 1'b0; state_in = S_RESP;
            end
         end
         S_ADV_PGET: begin
            key_in = p_rdata; lo_in = '0; hi_in = tcnt_ff; state_in = S_BS_RD;
         end
         S_BS_RD: begin
            if (lo_ff < hi_ff) state_in = S_BS_CMP;
            else begin
               t_addr = lo_ff[TAW-1:0];
               hold_in = {key_ff, ostart_ff, otime_ff};
               if (lo_ff < tcnt_ff) state_in = S_LK_CMP; // reuse: check equality
               else if (tcnt_ff >= TCW'(TABLE_DEPTH)) begin
                  stat_in = ST_TAB_FULL; pi_in = pi_ff + 1'b1; state_in = S_ADV_PRD;
               end else begin
                  t_we = 1'b1; t_wdata = {key_ff, ostart_ff, otime_ff};
                  tcnt_in = tcnt_ff + 1'b1;
                  pi_in = pi_ff + 1'b1; state_in = S_ADV_PRD;
               end
            end
         end
         S_BS_CMP: begin
            if (t_id < key_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_BS_RD;
         end
         S_LK_RD: begin
            if (lo_ff < hi_ff) begin
               state_in = S_LK_CMP;
               t_addr = mid[TAW-1:0];
            end else if (lo_ff < tcnt_ff) begin
               t_addr = lo_ff[TAW-1:0]; state_in = S_RD_GET;
            end else state_in = S_RESP;
         end
         S_LK_CMP: begin
            if (cmd_ff == CMD_LOOKUP) begin
               if (t_id < key_ff) lo_in = mid + 1'b1;
               else hi_in = mid;
               state_in = S_LK_RD;
            end else if (t_id == key_ff) begin
               t_addr = lo_ff[TAW-1:0]; t_we = 1'b1;
               pi_in = pi_ff + 1'b1; state_in = S_ADV_PRD;
            end else if (tcnt_ff >= TCW'(TABLE_DEPTH)) begin
               stat_in = ST_TAB_FULL; pi_in = pi_ff + 1'b1; state_in = S_ADV_PRD;
            end else begin
               hold_in = t_rdata; t_addr = lo_ff[TAW-1:0]; t_we = 1'b1;
               sp_in = lo_ff + 1'b1; state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            t_addr = sp_ff[TAW-1:0];
            if (sp_ff < tcnt_ff) state_in = S_SH_WR;
            else begin
               t_we = 1'b1; tcnt_in = tcnt_ff + 1'b1;
               pi_in = pi_ff + 1'b1; state_in = S_ADV_PRD;
            end
         end
         S_SH_WR: begin
            t_addr = sp_ff[TAW-1:0]; t_we = 1'b1; hold_in = t_rdata;
            sp_in = sp_ff + 1'b1; state_in = S_SH_RD;
         end
         S_RD_RD: begin
            t_addr = TAW'(idx_ff); state_in = S_RD_GET;
         end
         S_RD_GET: begin
            if (cmd_ff == CMD_READ || t_id == key_ff) begin
               found_in = 1'b1; rid_in = t_id;
               rtime_in = t_rdata[TimeW-1:0]; rstart_in = t_rdata[TimeW];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_found         = found_ff;
   assign rsp_id_out        = rid_ff;
   assign rsp_time_out      = rtime_ff;
   assign rsp_time_is_start = rstart_ff;
   assign rsp_table_size    = SizeW'(tcnt_ff);
   assign rsp_status        = stat_ff;
endmodule
`default_nettype wire

/* hw/rtl/eltt_checker.sv */
// Port-level checker for the event last-time table, bound to the top level.
// Depends on eltt_pkg.
`default_nettype none
module eltt_port_asserts
   import eltt_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_found,
   input wire logic [IdW-1:0]   rsp_id_out,
   input wire logic [SizeW-1:0] rsp_table_size,
   input wire logic [StatW-1:0] rsp_status
);
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_table_size))
      else $error("result dropped");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_id_out == '0) else $error("miss id");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK) else $error("found with error");
endmodule

bind event_last_time_table_unit eltt_port_asserts u_eltt_port_asserts (.*);
`default_nettype wire
